/* hdl/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int WIDTH_BITS = 16;
    localparam int SUM_W      = WIDTH_BITS + 3;
    localparam int DIST_W     = 16;
    localparam int DIVD_W     = SUM_W + 4;
    localparam int DIVR_W     = 12;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int TIMER_W    = 16;
    localparam int PING_W     = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 2'd3;

    localparam logic [7:0]  RST_TRIG_LEN  = 8'd20;
    localparam logic [15:0] RST_SETTLE    = 16'd50000;
    localparam logic [7:0]  RST_US_PER_CM = 8'd58;
    localparam logic [3:0]  RST_SAMPLES   = 4'd5;
    localparam logic [3:0]  MAX_SAMPLES   = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_WAIT,
        S_MEAS,
        S_SETTLE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic start_req;
        logic echo;
    } t_in_item;

    typedef struct packed {
        logic              trig;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance;
    } t_out_item;

    typedef struct packed {
        logic tmr_inc;
        logic tmr_clr;
        logic width_clr;
        logic width_set1;
        logic width_inc;
        logic meas_clr;
        logic ping_end;
        logic div_start;
        logic out_load;
        logic out_trig;
        logic out_busy;
        logic out_done;
    } t_ctrl_cmd;

    typedef struct packed {
        logic trig_end;
        logic settle_end;
        logic last_ping;
        logic div_busy;
    } t_dp_status;

endpackage

/* hdl/uer_ctrl.sv */
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: ping phases, divide wait and transfer handshake.
// ----------------------------------------------------------------------------
module uer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  uer_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  uer_pkg::t_dp_status i_status,
    output uer_pkg::t_ctrl_cmd  o_cmd
);
    import uer_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;
    logic   div_fin;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state != S_DIV) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign div_fin     = (r_state == S_DIV) && !i_status.div_busy && out_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_data.start_req) n_state = S_TRIG;
            end
            S_TRIG: begin
                if (accept && i_status.trig_end) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (accept && i_in_data.echo) n_state = S_MEAS;
            end
            S_MEAS: begin
                if (accept && !i_in_data.echo) n_state = S_SETTLE;
            end
            S_SETTLE: begin
                if (accept && i_status.settle_end) begin
                    n_state = i_status.last_ping ? S_DIV : S_TRIG;
                end
            end
            S_DIV: begin
                if (div_fin) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.meas_clr = accept && i_in_data.start_req;
            end
            S_TRIG: begin
                o_cmd.tmr_inc = accept;
                o_cmd.tmr_clr = accept && i_status.trig_end;
            end
            S_WAIT: begin
                o_cmd.width_set1 = accept && i_in_data.echo;
            end
            S_MEAS: begin
                o_cmd.width_inc = accept && i_in_data.echo;
                o_cmd.ping_end  = accept && !i_in_data.echo;
                o_cmd.tmr_clr   = accept && !i_in_data.echo;
            end
            S_SETTLE: begin
                o_cmd.tmr_inc   = accept;
                o_cmd.tmr_clr   = accept && i_status.settle_end;
                o_cmd.width_clr = accept && i_status.settle_end && !i_status.last_ping;
                o_cmd.div_start = accept && i_status.settle_end && i_status.last_ping;
            end
            S_DIV: begin
                o_cmd.out_done = div_fin;
            end
            default: o_cmd = '0;
        endcase
        o_cmd.out_load = (accept && (n_state != S_DIV)) || div_fin;
        o_cmd.out_trig = (n_state == S_TRIG);
        o_cmd.out_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.out_load && r_out_valid && !i_out_ready))
        else $error("output register overwritten before transfer");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV) && i_status.div_busy)
        else $error("divide not running after start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_done |-> !o_cmd.out_busy && !o_cmd.out_trig && o_cmd.out_load)
        else $error("done result with busy or trigger set");

endmodule

/* hdl/uer_dpath.sv */
// ----------------------------------------------------------------------------
// uer_dpath
// Config registers, timers, echo width accumulation, serial divider, output.
// ----------------------------------------------------------------------------
module uer_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  uer_pkg::t_ctrl_cmd              i_cmd,
    output uer_pkg::t_dp_status             o_status,
    output uer_pkg::t_out_item              o_out_data
);
    import uer_pkg::*;

    logic [7:0]            r_trig_len;
    logic [15:0]           r_settle;
    logic [7:0]            r_us_per_cm;
    logic [3:0]            r_samples;

    logic [TIMER_W-1:0]    r_timer;
    logic [TIMER_W-1:0]    n_timer;
    logic [WIDTH_BITS-1:0] r_width;
    logic [PING_W-1:0]     r_ping;
    logic [SUM_W-1:0]      r_sum;
    logic [DIST_W-1:0]     r_last_dist;

    logic [DIVR_W-1:0]     r_divisor;
    logic [DIVR_W-1:0]     r_div_rem;
    logic [DIVD_W-1:0]     r_div_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic                  r_div_busy;
    t_out_item             r_out_data;

    logic [3:0]            eff_samples;
    logic [7:0]            eff_upc;
    logic [DIVR_W:0]       rem_sh;
    logic                  quo_bit;
    logic [DIST_W-1:0]     quo_sat;

    assign eff_samples = (r_samples == 4'd0) ? 4'd1 :
                         (r_samples > MAX_SAMPLES) ? MAX_SAMPLES : r_samples;
    assign eff_upc     = (r_us_per_cm == 8'd0) ? 8'd1 : r_us_per_cm;
    assign n_timer     = r_timer + TIMER_W'(1);

    assign o_status.trig_end   = (n_timer >= {8'd0, r_trig_len});
    assign o_status.settle_end = (n_timer >= r_settle);
    assign o_status.last_ping  = (r_ping >= eff_samples);
    assign o_status.div_busy   = r_div_busy;

    assign rem_sh  = {r_div_rem, r_div_quo[DIVD_W-1]};
    assign quo_bit = (rem_sh >= {1'b0, r_divisor});
    assign quo_sat = (|r_div_quo[DIVD_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                   : r_div_quo[DIST_W-1:0];
    assign o_out_data = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_len  <= RST_TRIG_LEN;
            r_settle    <= RST_SETTLE;
            r_us_per_cm <= RST_US_PER_CM;
            r_samples   <= RST_SAMPLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIG_LEN:  r_trig_len  <= i_cfg_wdata[7:0];
                CFG_SETTLE:    r_settle    <= i_cfg_wdata[15:0];
                CFG_US_PER_CM: r_us_per_cm <= i_cfg_wdata[7:0];
                CFG_SAMPLES:   r_samples   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_width     <= '0;
            r_ping      <= '0;
            r_sum       <= '0;
            r_last_dist <= '0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cmd.meas_clr || i_cmd.tmr_clr) begin
                r_timer <= '0;
            end else if (i_cmd.tmr_inc) begin
                r_timer <= n_timer;
            end

            if (i_cmd.meas_clr || i_cmd.width_clr) begin
                r_width <= '0;
            end else if (i_cmd.width_set1) begin
                r_width <= WIDTH_BITS'(1);
            end else if (i_cmd.width_inc && !(&r_width)) begin
                r_width <= r_width + WIDTH_BITS'(1);
            end

            if (i_cmd.meas_clr) begin
                r_sum  <= '0;
                r_ping <= '0;
            end else if (i_cmd.ping_end) begin
                r_sum  <= r_sum + SUM_W'(r_width);
                r_ping <= r_ping + PING_W'(1);
            end

            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DIV_CNT_W'(DIVD_W);
            end else if (r_div_busy) begin
                r_div_cnt  <= r_div_cnt - DIV_CNT_W'(1);
                r_div_busy <= (r_div_cnt != DIV_CNT_W'(1));
            end

            if (i_cmd.out_done) begin
                r_last_dist <= quo_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_divisor <= {4'd0, eff_upc} * {8'd0, eff_samples};
            r_div_rem <= '0;
            r_div_quo <= {r_sum, 4'd0};
        end else if (r_div_busy) begin
            r_div_rem <= quo_bit ? DIVR_W'(rem_sh - {1'b0, r_divisor})
                                 : rem_sh[DIVR_W-1:0];
            r_div_quo <= {r_div_quo[DIVD_W-2:0], quo_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.trig     <= i_cmd.out_trig;
            r_out_data.busy_res <= i_cmd.out_busy;
            r_out_data.done_res <= i_cmd.out_done;
            r_out_data.distance <= i_cmd.out_done ? quo_sat : r_last_dist;
        end
    end

endmodule

/* hdl/ultrasonic_echo_ranger.sv */
// The result of an accepted tick is registered and offered in the cycle after acceptance.
// The tick that ends the last settle of a measurement has its result only after
//   a one-bit-per-cycle restoring divider, then the load once the output is free.
// Throughput: one tick per cycle while results are taken; no ticks are taken while
//   dividing, so the tick after that one waits until the divide result is loaded.
// Reset (i_rst_n low, synchronous): idle, registers to defaults, distance 0.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Averaged ultrasonic range measurement driven by microsecond ticks.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  uer_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output uer_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import uer_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    uer_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

/* sim/tb_ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger
// Self-checking bench for the ultrasonic echo ranger. A table of directed
// ticks covers reset values, zero and oversize register values and a register
// write during a measurement. Short runs then take the longest trigger and
// the largest divisor. A random section follows, mostly well-formed
// measurements with noise, under random register settings and random stalls
// on both sides. Every result transfer is checked against an in-bench model or a table row.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;

    import uer_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int unsigned RAND_TICKS     = 800;

    typedef enum logic { ROW_TICK, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  wdata;
        t_in_item               tick;
        bit                     typed;
        t_out_item              result;
    } t_dir_row;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_item               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // expectation override travels with the tick
    bit                     drv_typed = 1'b0;
    t_out_item              drv_exp   = '0;

    // ranger model state
    logic [7:0]             cfg_trig_len;
    logic [15:0]            cfg_settle;
    logic [7:0]             cfg_cm;
    logic [3:0]             cfg_samples;
    t_state                 rng_phase;
    logic [TIMER_W-1:0]     rng_timer;
    logic [WIDTH_BITS-1:0]  rng_width;
    logic [PING_W-1:0]      rng_ping;
    int unsigned            rng_sum;
    logic [DIST_W-1:0]      rng_dist;

    t_out_item              pending_results[$];
    t_dir_row               dir_rows[$];
    int unsigned            sent_ticks   = 0;
    int unsigned            pred_ticks   = 0;
    int unsigned            n_meas_done  = 0;
    int unsigned            n_cfg_writes = 0;
    int unsigned            n_fail       = 0;
    int                     quiet_cycles = 0;
    bit                     fast_mode    = 1'b0;
    bit                     hold_req     = 1'b0;

    ultrasonic_echo_ranger u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [3:0] eff_samples();
        if (cfg_samples == 4'd0) return 4'd1;
        if (cfg_samples > MAX_SAMPLES) return MAX_SAMPLES;
        return cfg_samples;
    endfunction

    task automatic ranger_reset();
        cfg_trig_len = RST_TRIG_LEN;
        cfg_settle   = RST_SETTLE;
        cfg_cm       = RST_US_PER_CM;
        cfg_samples  = RST_SAMPLES;
        rng_phase    = S_IDLE;
        rng_timer    = '0;
        rng_width    = '0;
        rng_ping     = '0;
        rng_sum      = 0;
        rng_dist     = '0;
    endtask

    task automatic ranger_config(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TRIG_LEN:  cfg_trig_len = val[7:0];
            CFG_SETTLE:    cfg_settle   = val[15:0];
            CFG_US_PER_CM: cfg_cm       = val[7:0];
            CFG_SAMPLES:   cfg_samples  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic ranger_tick(input t_in_item it, output t_out_item res);
        logic        done;
        int unsigned divisor;
        int unsigned quot;
        done = 1'b0;
        case (rng_phase)
            S_IDLE: begin
                if (it.start_req) begin
                    rng_sum   = 0;
                    rng_ping  = '0;
                    rng_timer = '0;
                    rng_width = '0;
                    rng_phase = S_TRIG;
                end
            end
            S_TRIG: begin
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= cfg_trig_len) begin
                    rng_timer = '0;
                    rng_phase = S_WAIT;
                end
            end
            S_WAIT: begin
                if (it.echo) begin
                    rng_width = WIDTH_BITS'(1);
                    rng_phase = S_MEAS;
                end
            end
            S_MEAS: begin
                if (it.echo) begin
                    if (rng_width != '1) rng_width = rng_width + 1'b1;
                end else begin
                    rng_sum   = rng_sum + rng_width;
                    rng_ping  = rng_ping + 1'b1;
                    rng_timer = '0;
                    rng_phase = S_SETTLE;
                end
            end
            S_SETTLE: begin
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= cfg_settle) begin
                    rng_timer = '0;
                    if (rng_ping >= eff_samples()) begin
                        divisor   = (cfg_cm == 8'd0 ? 1 : cfg_cm) * eff_samples();
                        quot      = (rng_sum * 16) / divisor;
                        rng_dist  = (quot > 65535) ? 16'hFFFF : quot[15:0];
                        done      = 1'b1;
                        rng_phase = S_IDLE;
                    end else begin
                        rng_width = '0;
                        rng_phase = S_TRIG;
                    end
                end
            end
            default: rng_phase = S_IDLE;
        endcase
        res.trig     = (rng_phase == S_TRIG);
        res.busy_res = (rng_phase != S_IDLE);
        res.done_res = done;
        res.distance = rng_dist;
    endtask

    // transfer monitor and checker
    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        if (!rst_n) begin
            ranger_reset();
            pending_results.delete();
        end else begin
            if (out_valid && out_ready) begin
                got = out_data;
                if (pending_results.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.trig !== want.trig) begin
                        $error("trig: expected %0d, got %0d", want.trig, got.trig);
                        n_fail++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, got.busy_res);
                        n_fail++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               want.done_res, got.done_res);
                        n_fail++;
                    end
                    if (got.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, got.distance);
                        n_fail++;
                    end
                    if (want.done_res) n_meas_done++;
                end
            end
            if (in_valid && in_ready) begin
                ranger_tick(in_data, want);
                if (drv_typed) want = drv_exp;
                pending_results.push_back(want);
                pred_ticks++;
            end
            if (cfg_we) ranger_config(cfg_idx, cfg_wdata);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ultrasonic_echo_ranger verification failed");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (fast_mode) begin
                out_ready <= 1'b1;
            end else if (stall_left != 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 9) < 7) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(10, 50);
            end
            @(posedge clk);
        end
    end

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (fast_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item exp);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= it;
        drv_typed <= typed;
        drv_exp   <= exp;
        do @(posedge clk); while (!in_ready);
        sent_ticks++;
    endtask

    task automatic tick(input logic start, input logic echo);
        t_in_item it;
        it.start_req = start;
        it.echo      = echo;
        send_item(it, 1'b0, '0);
    endtask

    task automatic wait_quiet();
        if (in_valid) in_valid <= 1'b0;
        wait (pred_ticks == sent_ticks);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        n_cfg_writes++;
    endtask

    // feed filler ticks until the model sits idle
    task automatic sync_idle();
        wait (pred_ticks == sent_ticks);
        while (rng_phase != S_IDLE) begin
            tick(1'b0, 1'($urandom_range(0, 1)));
            wait (pred_ticks == sent_ticks);
        end
    endtask

    // one well-formed measurement at the current settings
    task automatic measure(input int unsigned w_lo, input int unsigned w_hi);
        int unsigned trig_ticks;
        int unsigned settle_ticks;
        int unsigned pings;
        trig_ticks   = (cfg_trig_len == 8'd0) ? 1 : cfg_trig_len;
        settle_ticks = (cfg_settle == 16'd0) ? 1 : cfg_settle;
        pings        = eff_samples();
        tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (pings) begin
            repeat (trig_ticks)
                tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3)) tick(1'($urandom_range(0, 1)), 1'b0);
            repeat ($urandom_range(w_lo, w_hi)) tick(1'($urandom_range(0, 1)), 1'b1);
            tick(1'($urandom_range(0, 1)), 1'b0);
            repeat (settle_ticks)
                tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic t_dir_row row_tick(input logic start, input logic echo);
        t_dir_row r;
        r.kind           = ROW_TICK;
        r.idx            = '0;
        r.wdata          = '0;
        r.tick.start_req = start;
        r.tick.echo      = echo;
        r.typed          = 1'b0;
        r.result         = '0;
        return r;
    endfunction

    function automatic t_dir_row row_exp(input logic start, input logic echo,
                                         input logic trig, input logic busy,
                                         input logic done, input logic [15:0] dist_val);
        t_dir_row r;
        r                 = row_tick(start, echo);
        r.typed           = 1'b1;
        r.result.trig     = trig;
        r.result.busy_res = busy;
        r.result.done_res = done;
        r.result.distance = dist_val;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r       = row_tick(1'b0, 1'b0);
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.wdata = val;
        return r;
    endfunction

    initial begin
        int unsigned           rand_base;
        int unsigned           phase_no;
        int unsigned           wmask;
        int unsigned           r;
        logic [CFG_DATA_W-1:0] val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle after reset, echo ignored
        dir_rows.push_back(row_exp(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        dir_rows.push_back(row_exp(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
        // all registers zero: each acts as its smallest legal value
        dir_rows.push_back(row_cfg(CFG_TRIG_LEN, 16'h0000));
        dir_rows.push_back(row_cfg(CFG_SETTLE, 16'h0000));
        dir_rows.push_back(row_cfg(CFG_US_PER_CM, 16'hFF00));
        dir_rows.push_back(row_cfg(CFG_SAMPLES, 16'hFFF0));
        dir_rows.push_back(row_exp(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
        dir_rows.push_back(row_exp(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0));
        dir_rows.push_back(row_tick(1'b0, 1'b1));
        dir_rows.push_back(row_tick(1'b1, 1'b1));
        dir_rows.push_back(row_tick(1'b0, 1'b0));
        dir_rows.push_back(row_exp(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd32));
        dir_rows.push_back(row_exp(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd32));
        // settle shortened while it runs
        dir_rows.push_back(row_cfg(CFG_TRIG_LEN, 16'd1));
        dir_rows.push_back(row_cfg(CFG_SETTLE, 16'd3));
        dir_rows.push_back(row_cfg(CFG_US_PER_CM, 16'd16));
        dir_rows.push_back(row_cfg(CFG_SAMPLES, 16'd1));
        dir_rows.push_back(row_exp(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'd32));
        dir_rows.push_back(row_tick(1'b0, 1'b0));
        dir_rows.push_back(row_tick(1'b0, 1'b1));
        dir_rows.push_back(row_tick(1'b0, 1'b0));
        dir_rows.push_back(row_tick(1'b1, 1'b1));
        dir_rows.push_back(row_cfg(CFG_SETTLE, 16'd1));
        dir_rows.push_back(row_exp(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].wdata);
            else
                send_item(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].result);
        end

        // longest trigger, back to back
        write_reg(CFG_TRIG_LEN, 16'hFFFF);
        write_reg(CFG_SETTLE, 16'd2);
        write_reg(CFG_US_PER_CM, 16'd16);
        write_reg(CFG_SAMPLES, 16'd1);
        fast_mode = 1'b1;
        sync_idle();
        measure(1, 50);
        wait_quiet();
        fast_mode = 1'b0;

        // zero us-per-cm (acts as one) with oversize sample count, then the largest divisor
        write_reg(CFG_TRIG_LEN, 16'd0);
        write_reg(CFG_SETTLE, 16'd1);
        write_reg(CFG_US_PER_CM, 16'd0);
        write_reg(CFG_SAMPLES, 16'd15);
        sync_idle();
        measure(1, 50);
        write_reg(CFG_US_PER_CM, 16'd255);
        write_reg(CFG_SAMPLES, 16'd8);
        sync_idle();
        measure(1, 50);

        rand_base = sent_ticks;
        phase_no  = 0;
        while (sent_ticks - rand_base < RAND_TICKS) begin
            wait_quiet();
            wmask = $urandom_range(1, 15);
            if (wmask[0]) begin
                r        = $urandom_range(0, 9);
                val      = CFG_DATA_W'($urandom);
                val[7:0] = (r < 7) ? 8'($urandom_range(0, 4))
                         : (r < 9) ? 8'($urandom_range(5, 30)) : 8'd255;
                write_reg(CFG_TRIG_LEN, val);
            end
            if (wmask[1]) begin
                r   = $urandom_range(0, 9);
                val = (r < 7) ? CFG_DATA_W'($urandom_range(0, 5))
                    : (r < 9) ? CFG_DATA_W'($urandom_range(6, 40))
                              : CFG_DATA_W'($urandom_range(200, 400));
                write_reg(CFG_SETTLE, val);
            end
            if (wmask[2]) begin
                val = CFG_DATA_W'($urandom);
                write_reg(CFG_US_PER_CM, val);
            end
            if (wmask[3]) begin
                val      = CFG_DATA_W'($urandom);
                val[3:0] = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 3))
                                                      : 4'($urandom_range(4, 15));
                write_reg(CFG_SAMPLES, val);
            end
            if (phase_no == 0 || phase_no == 3) hold_req = 1'b1;
            repeat ($urandom_range(2, 5)) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    sync_idle();
                    r = $urandom_range(0, 9);
                    if (r < 8)      measure(1, 30);
                    else if (r < 9) measure(31, 200);
                    else            measure(200, 400);
                end else begin
                    repeat ($urandom_range(1, 30))
                        tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            phase_no++;
        end

        wait_quiet();
        repeat (40) @(posedge clk);

        $display("%0d ticks, %0d measurements, %0d register writes, %0d random phases",
                 sent_ticks, n_meas_done, n_cfg_writes, phase_no);
        $display("covered: zero and oversize registers, longest trigger, %s",
                 "largest divisor, mid-measurement writes, long stalls on both sides");
        if (n_fail == 0)
            $display("ultrasonic_echo_ranger verification clean");
        else
            $display("ultrasonic_echo_ranger verification failed");
        $finish;
    end

endmodule
